// ===== sv/qlbs_pkg.sv =====
// Shared types and constants for the queued LED blink sequencer.
`default_nettype none

package qlbs_pkg;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ENQUEUE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  blink_count;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } in_item_t;

  typedef struct packed {
    logic       led_lit;
    logic       request_dropped;
    logic       sequencer_busy;
    logic [3:0] queued_requests;
  } out_result_t;

  typedef struct packed {
    logic [7:0]  count;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } blink_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_REPLY
  } seq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic enqueue;
    logic tick_step;
    logic load_head;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_enqueue;
    logic active;
    logic queue_nonempty;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/qlbs_ctrl.sv =====
// Controller state machine of the queued LED blink sequencer.
`default_nettype none

module qlbs_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  output logic                 out_valid,
  output qlbs_pkg::dp_cmd_t    cmd,
  input  qlbs_pkg::dp_status_t status
);
  import qlbs_pkg::*;

  seq_state_t state_r;
  seq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_enqueue) begin
          cmd.enqueue = 1'b1;
          state_nxt   = ST_REPLY;
        end else if (status.active) begin
          cmd.tick_step = 1'b1;
          state_nxt     = ST_REPLY;
        end else if (status.queue_nonempty) begin
          // Head entry is being read from the store this cycle.
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_REPLY;
        end
      end
      ST_LOAD: begin
        cmd.load_head = 1'b1;
        state_nxt     = ST_REPLY;
      end
      ST_REPLY: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/qlbs_dp.sv =====
// Datapath of the queued LED blink sequencer: request FIFO, counters and LED level.
`default_nettype none

module qlbs_dp #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  qlbs_pkg::in_item_t    in_item,
  input  qlbs_pkg::dp_cmd_t     cmd,
  output qlbs_pkg::dp_status_t  status,
  output qlbs_pkg::out_result_t out_result
);
  import qlbs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  in_item_t   item_r;
  blink_req_t mem [QUEUE_DEPTH];
  blink_req_t rd_data_r;
  blink_req_t req_r;

  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] fill_r;
  logic          active_r;
  logic [7:0]    cyc_r;
  logic [15:0]   lit_r;
  logic [15:0]   dark_r;
  logic          led_r;
  logic          dropped_r;

  logic          full;
  logic          lit_adv;
  logic          dark_adv;
  logic          lit_done;
  logic [15:0]   lit_nxt;
  logic [15:0]   dark_nxt;
  logic [7:0]    cyc_nxt;
  logic          led_nxt;
  logic          active_nxt;
  logic [CW+3:0] fill_ext;

  assign full = (fill_r == CW'(QUEUE_DEPTH));

  // Store: written on an enqueue when not full, head read every cycle with registered data.
  always_ff @(posedge clk) begin
    if (cmd.enqueue && !full) begin
      mem[wr_ptr_r] <= blink_req_t'({item_r.blink_count, item_r.on_ticks, item_r.off_ticks});
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // One tick of a playing request: lit count first, then dark count.
  always_comb begin
    lit_nxt    = lit_r;
    dark_nxt   = dark_r;
    cyc_nxt    = cyc_r;
    led_nxt    = led_r;
    active_nxt = active_r;
    lit_adv    = 1'b0;
    dark_adv   = 1'b0;
    lit_done   = 1'b0;
    if (cyc_r < req_r.count) begin
      lit_adv = (lit_r < req_r.on_ticks);
      if (lit_adv) begin
        lit_nxt = lit_r + 16'd1;
        led_nxt = 1'b1;
      end
      lit_done = (lit_nxt >= req_r.on_ticks);
      dark_adv = lit_done && (dark_r < req_r.off_ticks);
      if (dark_adv) begin
        dark_nxt = dark_r + 16'd1;
        led_nxt  = 1'b0;
      end
      if (lit_done && (dark_nxt >= req_r.off_ticks)) begin
        cyc_nxt  = cyc_r + 8'd1;
        lit_nxt  = '0;
        dark_nxt = '0;
      end
    end else begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      active_r  <= 1'b0;
      req_r     <= '0;
      cyc_r     <= '0;
      lit_r     <= '0;
      dark_r    <= '0;
      led_r     <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        dropped_r <= 1'b0;
      end
      if (cmd.enqueue) begin
        if (full) begin
          dropped_r <= 1'b1;
        end else begin
          wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
          fill_r   <= fill_r + CW'(1);
        end
      end
      if (cmd.load_head) begin
        req_r    <= rd_data_r;
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
        fill_r   <= fill_r - CW'(1);
        active_r <= 1'b1;
        cyc_r    <= '0;
        lit_r    <= '0;
        dark_r   <= '0;
      end
      if (cmd.tick_step) begin
        lit_r    <= lit_nxt;
        dark_r   <= dark_nxt;
        cyc_r    <= cyc_nxt;
        led_r    <= led_nxt;
        active_r <= active_nxt;
      end
    end
  end

  assign status.is_enqueue     = (item_r.opcode == OP_ENQUEUE);
  assign status.active         = active_r;
  assign status.queue_nonempty = (fill_r != '0);

  assign fill_ext = {4'b0000, fill_r};

  assign out_result.led_lit         = led_r;
  assign out_result.request_dropped = dropped_r;
  assign out_result.sequencer_busy  = active_r;
  assign out_result.queued_requests = fill_ext[3:0];

endmodule

`default_nettype wire

// ===== sv/queued_led_blink_sequencer.sv =====
// Top level of the queued LED blink sequencer: controller and datapath.
`default_nettype none

// Usage:
// A transaction enters on in_item when start is high and busy is low. Its
// opcode either appends a blink request (count, on ticks, off ticks) to a
// FIFO of QUEUE_DEPTH entries or applies one time tick to the sequencer.
// Every transaction produces exactly one result on out_result, shown for one
// clock cycle with out_valid high; the receiver cannot hold it off.
// The result carries the LED level, a flag telling that this enqueue was
// dropped because the FIFO was full, whether a request is playing, and the
// number of requests waiting (low four bits of the count).
// Sequence: an enqueue, a tick on a playing request or a tick while idle
// with an empty FIFO passes from acceptance through the execute state to
// the result state; a tick that starts the head request takes an extra head
// load state between them. busy is low in the acceptance cycle, rises with
// the execute state and stays high through the result cycle, so a new
// transaction can be accepted in the cycle after out_valid, and not before.
// Reset (rst_n low, synchronous) empties the FIFO, stops playback and turns
// the LED dark; stored entries are not cleared and are never read unwritten.

module queued_led_blink_sequencer #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  qlbs_pkg::in_item_t    in_item,
  output logic                  out_valid,
  output qlbs_pkg::out_result_t out_result
);
  import qlbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller steps each transaction through capture, execute, an
  // optional head load, and the one-cycle result strobe.
  qlbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the FIFO, the active request and its counters.
  qlbs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
